### src/mm4_pkg.sv
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  localparam int DIM            = 4;
  localparam int DIM_BITS       = 2;
  localparam int NUM_ELEMS      = DIM * DIM;
  localparam int IDX_BITS       = 2 * DIM_BITS;
  localparam int SLOT_BITS      = IDX_BITS + 1;
  localparam int CNT_BITS       = IDX_BITS + DIM_BITS;
  localparam int FIELD_WIDTH    = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_ELEM_WIDTH = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(2 * NUM_ELEMS - 1);
  localparam logic [IDX_BITS-1:0]  LAST_INDEX = IDX_BITS'(NUM_ELEMS - 1);

  // One classified load transaction on its way to the compute side.
  typedef struct packed {
    logic                   start;
    logic                   right;
    logic [IDX_BITS-1:0]    addr;
    logic [FIELD_WIDTH-1:0] data;
  } job_t;

  typedef enum logic {
    BK_LOAD,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic pipe_active;
  } back_status_t;

endpackage

### src/mm4_if.sv
// Channel interfaces: element loads in, result elements out.
interface mm4_in_if import mm4_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [SLOT_BITS-1:0]          slot;
  logic signed [FIELD_WIDTH-1:0] element;

  modport source (output valid, slot, element, input ready);
  modport sink (input valid, slot, element, output ready);
endinterface

interface mm4_out_if import mm4_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [IDX_BITS-1:0]           out_index;
  logic signed [FIELD_WIDTH-1:0] product_value;
  logic                          last;

  modport source (output valid, out_index, product_value, last, input ready);
  modport sink (input valid, out_index, product_value, last, output ready);
endinterface

### src/mm4_front.sv
// Load front end: registers each transaction and tags its matrix, entry and start flag.
module mm4_front import mm4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mm4_in_if.sink load,
  output logic  job_valid,
  input  logic  job_ready,
  output job_t  job
);

  logic held;
  job_t job_reg;

  assign load.ready = !held || job_ready;
  assign job_valid  = held;
  assign job        = job_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load.ready) begin
      held <= load.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid && load.ready) begin
      job_reg.start <= (load.slot == LAST_SLOT);
      job_reg.right <= load.slot[SLOT_BITS-1];
      job_reg.addr  <= load.slot[IDX_BITS-1:0];
      job_reg.data  <= load.element;
    end
  end

endmodule

### src/mm4_queue.sv
// Short FIFO of classified loads between the front end and the compute side.
module mm4_queue import mm4_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_job;
    end
  end

endmodule

### src/mm4_back.sv
// Compute side: matrix stores, one multiply-accumulate pipeline and the result register.
module mm4_back import mm4_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  mm4_out_if.source    result,
  output back_status_t status
);

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] MAX_ACC =
    {{(ACC_W - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MIN_ACC = ~MAX_ACC;

  logic [ELEM_WIDTH-1:0] left_mem  [NUM_ELEMS];
  logic [ELEM_WIDTH-1:0] right_mem [NUM_ELEMS];

  back_state_t         state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                issue;
  logic                adv;

  logic [DIM_BITS-1:0] term_i;
  logic [DIM_BITS-1:0] row;
  logic [DIM_BITS-1:0] col;

  logic                         s1_v, s2_v, s3_v;
  logic [DIM_BITS-1:0]          s1_i, s2_i;
  logic [IDX_BITS-1:0]          s1_k, s2_k, s3_k;
  logic signed [ELEM_WIDTH-1:0] a_q, b_q;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      prod_ext, term, acc_base, sum, acc;
  logic signed [ELEM_WIDTH-1:0] sat_val;

  logic                          out_valid;
  logic [IDX_BITS-1:0]           out_index;
  logic signed [FIELD_WIDTH-1:0] product_value;
  logic                          last;

  // counter walks col, row, then the four terms of each dot product
  assign term_i = cnt[DIM_BITS-1:0];
  assign row    = cnt[IDX_BITS-1:DIM_BITS];
  assign col    = cnt[CNT_BITS-1:IDX_BITS];

  // the whole pipeline advances only when the result register can take a value
  assign adv = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    job_ready  = 1'b0;
    issue      = 1'b0;
    case (state)
      BK_LOAD: begin
        job_ready = 1'b1;
        if (job_valid && job.start) begin
          state_next = BK_RUN;
          cnt_next   = '0;
        end
      end
      BK_RUN: begin
        if (adv) begin
          issue    = 1'b1;
          cnt_next = cnt + 1'b1;
          if (&cnt) begin
            state_next = BK_LOAD;
          end
        end
      end
      default: begin
        state_next = BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      if (job.right) begin
        right_mem[job.addr] <= job.data[ELEM_WIDTH-1:0];
      end else begin
        left_mem[job.addr] <= job.data[ELEM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q <= left_mem[{term_i, row}];
      b_q <= right_mem[{col, term_i}];
    end
  end

  assign prod_ext = {{2{prod[PROD_W-1]}}, prod};
  assign term     = prod_ext >>> FRAC_BITS;
  assign acc_base = (s2_i == '0) ? '0 : acc;
  assign sum      = acc_base + term;

  always_comb begin
    if (acc > MAX_ACC) begin
      sat_val = MAX_ACC[ELEM_WIDTH-1:0];
    end else if (acc < MIN_ACC) begin
      sat_val = MIN_ACC[ELEM_WIDTH-1:0];
    end else begin
      sat_val = acc[ELEM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= issue;
      s2_v      <= s1_v;
      s3_v      <= s2_v && (s2_i == DIM_BITS'(DIM - 1));
      out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i <= term_i;
      s1_k <= {col, row};
      s2_i <= s1_i;
      s2_k <= s1_k;
      prod <= a_q * b_q;
      s3_k <= s2_k;
      if (s2_v) begin
        acc <= sum;
      end
      if (s3_v) begin
        out_index     <= s3_k;
        product_value <= FIELD_WIDTH'(sat_val);
        last          <= (s3_k == LAST_INDEX);
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.out_index     = out_index;
  assign result.product_value = product_value;
  assign result.last          = last;

  assign status.busy        = (state == BK_RUN);
  assign status.pipe_active = s1_v || s2_v || s3_v;

endmodule

### src/matrix_multiply_4x4.sv
// 4x4 fixed-point matrix multiplier, column-major A times B with saturated results.
// Loads are taken one per cycle, unless the load channel stalls, into a front register
// and a two-entry queue; the compute side drains them into two 16-entry stores. A
// load of slot 31 starts a product, run on a single multiply-accumulate pipeline fed
// by one read of each store per cycle while the result channel does not stall. Each of
// the sixteen result elements sums four terms; the terms pass the read, multiply and
// accumulate registers, and each finished sum the result register. While a product
// runs, further loads collect in the queue and the front register, then stall the load
// channel until the product has been issued. A stall on the result channel holds the
// whole pipeline. No clearing pass is needed after reset.
module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  mm4_in_if.sink    load,
  mm4_out_if.source result
);

  logic         fq_valid, fq_ready;
  job_t         fq_job;
  logic         qb_valid, qb_ready;
  job_t         qb_job;
  back_status_t status;

  mm4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  mm4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  mm4_back #(
    .FRAC_BITS  (FRAC_BITS),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .result    (result),
    .status    (status)
  );

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (qb_valid && qb_ready && qb_job.start) |=> status.busy)
    else $error("start transaction did not begin a product");

  a_busy_blocks_loads: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !qb_ready)
    else $error("store written while a product is being issued");

  a_drain_after_issue: assert property (@(posedge clk) disable iff (rst)
    $fell(status.busy) |-> status.pipe_active)
    else $error("pipeline empty right after the last issue");

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.last == (result.out_index == LAST_INDEX)))
    else $error("last flag does not match the final result position");

endmodule

### tb/tb_top.sv
// Self-checking testbench for matrix_multiply_4x4: random element loads, predicted products.
module tb_top import mm4_pkg::*; ();

  localparam int   IDLE_PCT       = 30;
  localparam int   RANDOM_ITEMS   = 280;
  localparam int   CYCLE_LIMIT    = 300_000;
  localparam int   DRAIN_CYCLES   = 120;
  localparam int   MAX_PRINTED    = 200;
  localparam int   STEADY_LOAD_LO = 140;
  localparam int   STEADY_LOAD_HI = 240;
  localparam int   STEADY_RES_LO  = 160;
  localparam int   STEADY_RES_HI  = 320;
  localparam logic [FIELD_WIDTH-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_WIDTH-1:0] Q_MIN = 32'h8000_0000;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic [SLOT_BITS-1:0]   slot;
    logic [FIELD_WIDTH-1:0] element;
  } load_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]           index;
    logic signed [FIELD_WIDTH-1:0] value;
    logic                          last;
  } result_t;

  class matrix_product_board;
    logic [FIELD_WIDTH-1:0] left_store[NUM_ELEMS];
    logic [FIELD_WIDTH-1:0] right_store[NUM_ELEMS];
    result_t expected_products[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Sum of four floor-shifted products, saturated to the signed 32-bit range.
    function logic signed [FIELD_WIDTH-1:0] product_element(int row, int col);
      longint acc;
      longint a;
      longint b;
      acc = 0;
      for (int i = 0; i < DIM; i++) begin
        a = longint'($signed(left_store[i*DIM + row]));
        b = longint'($signed(right_store[col*DIM + i]));
        acc += (a * b) >>> DEF_FRAC_BITS;
      end
      if (acc > SUM_MAX) return Q_MAX;
      if (acc < SUM_MIN) return Q_MIN;
      return acc[FIELD_WIDTH-1:0];
    endfunction

    task note_load(logic [SLOT_BITS-1:0] slot, logic [FIELD_WIDTH-1:0] element);
      result_t r;
      if (slot[SLOT_BITS-1]) right_store[slot[IDX_BITS-1:0]] = element;
      else left_store[slot[IDX_BITS-1:0]] = element;
      if (slot == LAST_SLOT) begin
        for (int col = 0; col < DIM; col++) begin
          for (int row = 0; row < DIM; row++) begin
            r.index = IDX_BITS'(col*DIM + row);
            r.value = product_element(row, col);
            r.last  = (r.index == LAST_INDEX);
            expected_products.push_back(r);
          end
        end
      end
    endtask

    task check_result(logic [IDX_BITS-1:0] index, logic signed [FIELD_WIDTH-1:0] value,
                      logic last);
      result_t want;
      if (expected_products.size() == 0) begin
        report($sformatf("unexpected result index %0d value %0d", index, value));
        return;
      end
      want = expected_products.pop_front();
      if (index !== want.index)
        report($sformatf("out_index %0d, want %0d", index, want.index));
      if (value !== want.value)
        report($sformatf("index %0d product_value %0d, want %0d", want.index, value,
                         want.value));
      if (last !== want.last)
        report($sformatf("index %0d last %b, want %b", want.index, last, want.last));
    endtask

    function int pending();
      return expected_products.size();
    endfunction

    task check_leftovers();
      if (expected_products.size() != 0)
        report($sformatf("%0d results never arrived", expected_products.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   results_seen = 0;
  load_t load_plan[$];
  matrix_product_board board;

  mm4_in_if  load_if ();
  mm4_out_if result_if ();

  matrix_multiply_4x4 DUT (
    .clk    (clk),
    .rst    (rst),
    .load   (load_if.sink),
    .result (result_if.source)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
      $display("matrix_multiply_4x4 test failed");
      $finish;
    end
  end

  function automatic int idle_cycles();
    int n;
    n = 0;
    while ($urandom_range(0, 99) < IDLE_PCT) n++;
    return n;
  endfunction

  // Mostly small Q16.16 values so that sums stay in range; extremes and raw words too.
  function automatic logic [FIELD_WIDTH-1:0] random_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      4, 5:       return $urandom;
      6:          return Q_MAX;
      7:          return Q_MIN;
      8:          return $urandom_range(0, 15) - 32'd8;
      default:    return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
    endcase
  endfunction

  task automatic add_load(logic [SLOT_BITS-1:0] slot, logic [FIELD_WIDTH-1:0] element);
    load_t t;
    t.slot    = slot;
    t.element = element;
    load_plan.push_back(t);
  endtask

  task automatic add_directed();
    // every element at the largest value: positive saturation everywhere
    for (int s = 0; s < 2*NUM_ELEMS; s++) add_load(SLOT_BITS'(s), Q_MAX);
    // last column of B down to a single smallest value: negative saturation there
    add_load(LAST_SLOT - SLOT_BITS'(3), '0);
    add_load(LAST_SLOT - SLOT_BITS'(2), '0);
    add_load(LAST_SLOT - SLOT_BITS'(1), '0);
    add_load(LAST_SLOT, Q_MIN);
    // one LSB below zero times the largest A: products round toward minus infinity
    add_load(LAST_SLOT, '1);
    add_load(LAST_SLOT, 32'd1);
    // ordinary writes with no result, then a product with half-LSB fractions
    add_load(SLOT_BITS'(0), 32'h0001_0000);
    add_load(SLOT_BITS'(5), 32'hFFFF_8000);
    add_load(LAST_SLOT, 32'h0000_8001);
  endtask

  task automatic add_random(int count);
    int stop_at;
    int perm[2*NUM_ELEMS-1];
    int j;
    int tmp;
    int kind;
    stop_at = load_plan.size() + count;
    while (load_plan.size() < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // full reload in random order, product started by the last slot
        for (int k = 0; k < 2*NUM_ELEMS-1; k++) perm[k] = k;
        for (int k = 2*NUM_ELEMS-2; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        for (int k = 0; k < 2*NUM_ELEMS-1; k++)
          add_load(SLOT_BITS'(perm[k]), random_element());
        add_load(LAST_SLOT, random_element());
      end else if (kind < 85) begin
        repeat ($urandom_range(0, 7))
          add_load(SLOT_BITS'($urandom_range(0, LAST_SLOT - 1)), random_element());
        add_load(LAST_SLOT, random_element());
      end else begin
        // broken sequence: writes that never start a product
        repeat ($urandom_range(1, 4))
          add_load(SLOT_BITS'($urandom_range(0, LAST_SLOT - 1)), random_element());
      end
    end
  endtask

  task automatic drive_loads();
    int gap;
    for (int n = 0; n < load_plan.size(); n++) begin
      gap = (n >= STEADY_LOAD_LO && n < STEADY_LOAD_HI) ? 0 : idle_cycles();
      if (gap > 0) begin
        load_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      load_if.valid   <= 1'b1;
      load_if.slot    <= load_plan[n].slot;
      load_if.element <= load_plan[n].element;
      @(posedge clk);
      while (!load_if.ready) @(posedge clk);
      board.note_load(load_plan[n].slot, load_plan[n].element);
    end
    load_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        board.check_result(result_if.out_index, result_if.product_value, result_if.last);
        results_seen <= results_seen + 1;
      end
      result_if.ready <= (results_seen >= STEADY_RES_LO && results_seen < STEADY_RES_HI)
                         || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    board = new();
    rst = 1'b1;
    load_if.valid = 1'b0;
    load_if.slot = '0;
    load_if.element = '0;
    add_directed();
    add_random(RANDOM_ITEMS);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    drive_loads();
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.check_leftovers();
    if (board.errors == 0) begin
      $display("matrix_multiply_4x4 test passed");
    end else begin
      $display("matrix_multiply_4x4 test failed");
    end
    $finish;
  end

endmodule
